@@ hw/rtl/pds_pkg.sv @@
`default_nettype none

package pds_pkg;

  // Table size and derived widths
  localparam int MAX_PROC  = 16;
  localparam int IDX_W     = (MAX_PROC > 1) ? $clog2(MAX_PROC) : 1;
  localparam int CNT_W     = IDX_W + 1;

  // Fixed field widths
  localparam int TIME_W    = 24;
  localparam int PRIO_W    = 4;
  localparam int ORIGIN_W  = 4;
  localparam int QUANT_W   = 16;
  localparam int MODE_W    = 2;
  localparam int FUNC_W    = 2;

  localparam logic [QUANT_W-1:0] QUANT_RESET = 16'd10;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_CLEAR    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_LOAD     = 2'd1;
  localparam logic [FUNC_W-1:0] FN_DISPATCH = 2'd2;

  // Scheduling policies
  localparam logic [MODE_W-1:0] MODE_FIFO = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RR   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PRIO = 2'd2;

  // Register indexes on the configuration port
  localparam logic REG_MODE    = 1'b0;
  localparam logic REG_QUANTUM = 1'b1;

  // One table entry as held in the memory
  typedef struct packed {
    logic [TIME_W-1:0]   rem;
    logic [PRIO_W-1:0]   prio;
    logic [ORIGIN_W-1:0] origin;
  } entry_t;

  // Controller states
  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SORT_A  = 7'b0000010,
    S_SORT_J  = 7'b0000100,
    S_SORT_WB = 7'b0001000,
    S_PICK    = 7'b0010000,
    S_UPD     = 7'b0100000,
    S_OUT     = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/process_dispatch_scheduler.sv @@
`default_nettype none

// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   func, burst_time, prio_level
// out       output     out_valid/out_stall proc_id, granted_time, proc_finished, all_done
// cfg       APB        psel/penable/pready sched_mode (0x0), time_quantum (0x4)
//
// Clear and load are taken in the idle state; a dispatch steps through accept, pick,
// read-modify-write of the entry (skipped when none is left) and output register.
// It waits in the output step while the output stalls. The first priority dispatch
// after a clear or load exchange-sorts the table memory if it holds two or more entries.
// rst is synchronous: flags, count, cursor, state, out_valid and configuration
// registers clear; the memory and the datapath registers do not.
// A waiting result sits in the output register; items are taken only when idle.

module process_dispatch_scheduler (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [pds_pkg::FUNC_W-1:0]    func,
  input  wire logic [pds_pkg::TIME_W-1:0]    burst_time,
  input  wire logic [pds_pkg::PRIO_W-1:0]    prio_level,
  // output channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [pds_pkg::ORIGIN_W-1:0]       proc_id,
  output logic [pds_pkg::TIME_W-1:0]         granted_time,
  output logic                               proc_finished,
  output logic                               all_done,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  import pds_pkg::*;

  // Configuration registers
  logic [MODE_W-1:0]  sched_mode;
  logic [QUANT_W-1:0] time_quantum;

  // Control state
  state_t             state;
  logic [CNT_W-1:0]   entry_count;
  logic [CNT_W-1:0]   serve_cursor;
  logic               sorted_flag;
  logic [MAX_PROC-1:0] entry_done;
  logic [IDX_W-1:0]   si;
  logic [IDX_W-1:0]   sj;
  logic [IDX_W-1:0]   sel_reg;
  entry_t             a_reg;

  // Staged result
  logic [ORIGIN_W-1:0] res_id;
  logic [TIME_W-1:0]   res_time;
  logic                res_fin;
  logic                res_all;

  // Table memory
  entry_t             mem [MAX_PROC];
  entry_t             rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;

  logic in_acc;
  logic out_free;
  logic cfg_wr;

  logic [MAX_PROC-1:0] cand;
  logic [MAX_PROC-1:0] cand_hi;
  logic [CNT_W-1:0]    rr_start;
  logic [IDX_W-1:0]    first_all;
  logic [IDX_W-1:0]    first_hi;
  logic [IDX_W-1:0]    pick_sel;
  logic                found;

  logic                do_swap;
  logic                j_more;
  logic                i_more;
  logic                rr_more;
  logic [TIME_W-1:0]   quant_ext;
  logic [TIME_W-1:0]   new_rem;
  logic [CNT_W-1:0]    cursor_inc;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;

  // Register read-back
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_QUANTUM) begin
      prdata = 32'(time_quantum);
    end else begin
      prdata = 32'(sched_mode);
    end
  end

  // Candidate search over the done flags
  always_comb begin
    rr_start  = (serve_cursor < entry_count) ? serve_cursor : '0;
    first_all = '0;
    first_hi  = '0;
    for (int i = 0; i < MAX_PROC; i++) begin
      cand[i]    = !entry_done[i] && (CNT_W'(i) < entry_count);
      cand_hi[i] = cand[i] && (CNT_W'(i) >= rr_start);
    end
    for (int i = MAX_PROC - 1; i >= 0; i--) begin
      if (cand[i]) begin
        first_all = IDX_W'(i);
      end
      if (cand_hi[i]) begin
        first_hi = IDX_W'(i);
      end
    end
    found = |cand;
    if (sched_mode == MODE_RR && |cand_hi) begin
      pick_sel = first_hi;
    end else begin
      pick_sel = first_all;
    end
  end

  // Sort and update arithmetic
  assign do_swap    = (a_reg.prio > rd_data.prio);
  assign j_more     = ((CNT_W'(sj) + CNT_W'(1)) < entry_count);
  assign i_more     = ((CNT_W'(si) + CNT_W'(2)) < entry_count);
  assign quant_ext  = TIME_W'(time_quantum);
  assign rr_more    = (rd_data.rem > quant_ext);
  assign cursor_inc = CNT_W'(sel_reg) + CNT_W'(1);

  always_comb begin
    if (sched_mode == MODE_RR && rr_more) begin
      new_rem = rd_data.rem - quant_ext;
    end else begin
      new_rem = '0;
    end
  end

  // Memory port control
  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = si;
    wr_data = a_reg;
    case (state)
      S_IDLE: begin
        if (in_acc && func == FN_LOAD && entry_count < CNT_W'(MAX_PROC)) begin
          wr_en   = 1'b1;
          wr_addr = entry_count[IDX_W-1:0];
          wr_data = '{rem: burst_time, prio: prio_level, origin: ORIGIN_W'(entry_count)};
        end
      end
      S_SORT_A: begin
        rd_addr = si + IDX_W'(1);
      end
      S_SORT_J: begin
        rd_addr = sj + IDX_W'(1);
        if (do_swap) begin
          wr_en   = 1'b1;
          wr_addr = sj;
        end
      end
      S_SORT_WB: begin
        rd_addr = si + IDX_W'(1);
        wr_en   = 1'b1;
        wr_addr = si;
      end
      S_PICK: begin
        rd_addr = pick_sel;
      end
      S_UPD: begin
        wr_en   = 1'b1;
        wr_addr = sel_reg;
        wr_data = '{rem: new_rem, prio: rd_data.prio, origin: rd_data.origin};
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // Table memory, one read and one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sched_mode   <= MODE_FIFO;
      time_quantum <= QUANT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MODE) begin
        sched_mode <= pwdata[MODE_W-1:0];
      end else begin
        time_quantum <= pwdata[QUANT_W-1:0];
      end
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk) begin
    case (state)
      S_SORT_A: begin
        a_reg <= rd_data;
        sj    <= si + IDX_W'(1);
      end
      S_SORT_J: begin
        if (do_swap) begin
          a_reg <= rd_data;
        end
        if (j_more) begin
          sj <= sj + IDX_W'(1);
        end
      end
      S_PICK: begin
        sel_reg  <= pick_sel;
        res_id   <= '0;
        res_time <= '0;
        res_fin  <= 1'b0;
        res_all  <= 1'b1;
      end
      S_UPD: begin
        res_id  <= rd_data.origin;
        res_all <= 1'b0;
        if (sched_mode == MODE_RR) begin
          res_time <= quant_ext;
          res_fin  <= !rr_more;
        end else begin
          res_time <= rd_data.rem;
          res_fin  <= 1'b1;
        end
      end
      default: begin
        a_reg <= a_reg;
      end
    endcase
    if (state == S_OUT && out_free) begin
      proc_id       <= res_id;
      granted_time  <= res_time;
      proc_finished <= res_fin;
      all_done      <= res_all;
    end
  end

  // Controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entry_count  <= '0;
      serve_cursor <= '0;
      sorted_flag  <= 1'b0;
      entry_done   <= '0;
      si           <= '0;
      out_valid    <= 1'b0;
    end else begin
      // output valid: set when a staged result moves out, cleared when taken
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (func)
              FN_CLEAR: begin
                entry_count  <= '0;
                serve_cursor <= '0;
                sorted_flag  <= 1'b0;
                entry_done   <= '0;
              end
              FN_LOAD: begin
                if (entry_count < CNT_W'(MAX_PROC)) begin
                  entry_done[entry_count[IDX_W-1:0]] <= 1'b0;
                  entry_count <= entry_count + CNT_W'(1);
                  sorted_flag <= 1'b0;
                end
              end
              FN_DISPATCH: begin
                si <= '0;
                if (sched_mode == MODE_PRIO && !sorted_flag) begin
                  if (entry_count >= CNT_W'(2)) begin
                    state <= S_SORT_A;
                  end else begin
                    sorted_flag <= 1'b1;
                    state       <= S_PICK;
                  end
                end else begin
                  state <= S_PICK;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SORT_A: begin
          state <= S_SORT_J;
        end
        S_SORT_J: begin
          if (do_swap) begin
            entry_done[si] <= entry_done[sj];
            entry_done[sj] <= entry_done[si];
          end
          if (!j_more) begin
            state <= S_SORT_WB;
          end
        end
        S_SORT_WB: begin
          if (i_more) begin
            si    <= si + IDX_W'(1);
            state <= S_SORT_A;
          end else begin
            sorted_flag <= 1'b1;
            state       <= S_PICK;
          end
        end
        S_PICK: begin
          state <= found ? S_UPD : S_OUT;
        end
        S_UPD: begin
          if (sched_mode != MODE_RR || !rr_more) begin
            entry_done[sel_reg] <= 1'b1;
          end
          if (sched_mode == MODE_RR) begin
            serve_cursor <= (cursor_inc >= entry_count) ? '0 : cursor_inc;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_PROC))
    else $error("entry count beyond table size");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (in_acc && func == FN_CLEAR) |=> (entry_count == '0 && entry_done == '0))
    else $error("clear did not empty the table");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> (out_valid && state == S_IDLE))
    else $error("staged result not presented");

  a_finish_marks_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD && sched_mode != MODE_RR) |=> entry_done[$past(sel_reg)])
    else $error("served entry not marked done");

endmodule

`default_nettype wire
